>>> hdl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by the step logic, the top level and the testbench; no dependencies.
package u8d_pkg;

    // Status codes of a result item
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_STRAY       = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_TRUNCATED   = 2'd3;

    // Lead and continuation byte payload masks
    localparam logic [7:0] MASK_LEAD2 = 8'h1f;
    localparam logic [7:0] MASK_LEAD3 = 8'h0f;
    localparam logic [7:0] MASK_CONT  = 8'h3f;

    // Sequence lengths that decode to a code point
    localparam logic [3:0] LEN_TWO   = 4'd2;
    localparam logic [3:0] LEN_THREE = 4'd3;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [2:0]  bytes_left;
        logic [15:0] partial_code;
        logic [3:0]  current_length;
        logic        unsupported;
    } t_state;

    // One result item
    typedef struct packed {
        logic [15:0] code_point;
        logic [3:0]  seq_length;
        logic [1:0]  status;
    } t_result;

endpackage

>>> hdl/u8d_if.sv
// Valid/ready channel interfaces for the UTF-8 stream decoder.
// Depends on nothing; the byte channel feeds the decoder, the code channel leaves it.
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface u8d_code_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic [3:0]  seq_length;
    logic [1:0]  status;

    modport source (output valid, output code_point, output seq_length, output status,
                    input ready);
    modport sink   (input valid, input code_point, input seq_length, input status,
                    output ready);
endinterface

>>> hdl/u8d_step.sv
// Combinational decode of one byte against the current decoder state.
// Depends on u8d_pkg for the state and result types and status codes.
module u8d_step (
    input  u8d_pkg::t_state  i_state,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_buffer,
    output u8d_pkg::t_state  o_state,
    output u8d_pkg::t_result o_result,
    output logic             o_result_valid
);

    logic [3:0] lead_ones;
    logic [2:0] left_dec;
    logic       done;

    // Count of leading ones, 0..8 (priority encoder)
    always_comb begin
        casez (i_data_byte)
            8'b0???????: lead_ones = 4'd0;
            8'b10??????: lead_ones = 4'd1;
            8'b110?????: lead_ones = 4'd2;
            8'b1110????: lead_ones = 4'd3;
            8'b11110???: lead_ones = 4'd4;
            8'b111110??: lead_ones = 4'd5;
            8'b1111110?: lead_ones = 4'd6;
            8'b11111110: lead_ones = 4'd7;
            default:     lead_ones = 4'd8;
        endcase
    end

    assign left_dec = i_state.bytes_left - 3'd1;

    // Next state and result
    always_comb begin
        o_state        = i_state;
        o_result       = '0;
        o_result_valid = 1'b0;
        done           = 1'b0;

        if (i_state.bytes_left == 3'd0) begin
            if (lead_ones == 4'd0) begin
                // plain ASCII byte
                o_result.code_point = {8'h00, i_data_byte};
                o_result.seq_length = 4'd1;
                o_result.status     = u8d_pkg::ST_OK;
                o_result_valid      = 1'b1;
                o_state             = '0;
                done                = 1'b1;
            end else if (lead_ones == 4'd1) begin
                // continuation byte with no open sequence
                o_result.seq_length = 4'd1;
                o_result.status     = u8d_pkg::ST_STRAY;
                o_result_valid      = 1'b1;
                o_state             = '0;
                done                = 1'b1;
            end else begin
                // lead byte opens a sequence; longer than three bytes is unsupported
                o_state.current_length = lead_ones;
                o_state.bytes_left     = lead_ones[2:0] - 3'd1;
                o_state.unsupported    = (lead_ones > u8d_pkg::LEN_THREE);
                case (lead_ones)
                    u8d_pkg::LEN_TWO:
                        o_state.partial_code = {8'h00, i_data_byte & u8d_pkg::MASK_LEAD2};
                    u8d_pkg::LEN_THREE:
                        o_state.partial_code = {8'h00, i_data_byte & u8d_pkg::MASK_LEAD3};
                    default:
                        o_state.partial_code = '0;
                endcase
            end
        end else begin
            // continuation byte: shift in six bits unless the lead was unsupported
            if (!i_state.unsupported) begin
                o_state.partial_code = {i_state.partial_code[9:0],
                                        i_data_byte[5:0] & u8d_pkg::MASK_CONT[5:0]};
            end
            o_state.bytes_left = left_dec;
            if (left_dec == 3'd0) begin
                o_result.code_point = i_state.unsupported ? 16'h0000 : o_state.partial_code;
                o_result.seq_length = i_state.current_length;
                o_result.status     = i_state.unsupported ? u8d_pkg::ST_UNSUPPORTED
                                                          : u8d_pkg::ST_OK;
                o_result_valid      = 1'b1;
                o_state             = '0;
                done                = 1'b1;
            end
        end

        // end-of-buffer mark cuts an open sequence short
        if (!done && i_end_of_buffer) begin
            o_result.code_point = '0;
            o_result.seq_length = o_state.current_length - {1'b0, o_state.bytes_left};
            o_result.status     = u8d_pkg::ST_TRUNCATED;
            o_result_valid      = 1'b1;
            o_state             = '0;
        end
    end

endmodule

>>> hdl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, top level: byte channel in, code point channel out.
// Depends on u8d_pkg, the interfaces in u8d_if.sv and the step logic u8d_step.
//
// Usage:
//   i_byte carries one byte of encoded text per item, with end_of_buffer set
//   on the last byte of a buffer. o_code carries one item per decoded
//   character or per error: code_point, seq_length (bytes consumed) and
//   status (ok, stray continuation, unsupported lead, truncated).
//   Bytes that only extend an open sequence produce no item.
//   Latency: the result of a byte appears on o_code the cycle after that
//   byte is accepted. Throughput: one byte per cycle unless o_code stalls,
//   set by the lead-byte encoder and shift-merge feeding the result register.
//   Reset (i_rst_n low, synchronous) clears the decoder state and empties the
//   result register. When the receiver stalls, the result register holds its
//   item and i_byte.ready drops; ready stays high as long as the result
//   register is empty or being taken in the same cycle.
module utf8_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8d_byte_if.sink    i_byte,
    u8d_code_if.source  o_code
);

    u8d_pkg::t_state  r_state;
    u8d_pkg::t_state  n_state;
    u8d_pkg::t_result r_out;
    u8d_pkg::t_result n_result;
    logic             n_result_valid;
    logic             r_out_valid;
    logic             in_accept;

    // Decode of the byte on the input channel
    u8d_step u_step (
        .i_state         (r_state),
        .i_data_byte     (i_byte.data_byte),
        .i_end_of_buffer (i_byte.end_of_buffer),
        .o_state         (n_state),
        .o_result        (n_result),
        .o_result_valid  (n_result_valid)
    );

    // Handshake: take a byte whenever the result register can move on
    assign i_byte.ready = !r_out_valid || o_code.ready;
    assign in_accept    = i_byte.valid && i_byte.ready;

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && n_result_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && n_result_valid) begin
            r_out <= n_result;
        end
    end

    assign o_code.valid      = r_out_valid;
    assign o_code.code_point = r_out.code_point;
    assign o_code.seq_length = r_out.seq_length;
    assign o_code.status     = r_out.status;

    // Checks
    a_err_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_code.valid && (o_code.status != u8d_pkg::ST_OK) |-> o_code.code_point == 16'h0000)
        else $error("error result with nonzero code point");

    a_eob_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_byte.end_of_buffer |=> r_state == '0)
        else $error("state not cleared after end of buffer");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_code.valid |-> o_code.seq_length != 4'd0)
        else $error("result with zero length");

    a_state_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bytes_left == 3'd0) == (r_state.current_length == 4'd0))
        else $error("open sequence length and bytes left disagree");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> r_out_valid && !o_code.ready)
        else $error("input stalled with room in result register");

endmodule

>>> tb/utf8_stream_decoder_unit_test.sv
// Self-checking testbench for utf8_stream_decoder_unit: directed and random byte streams.
// Depends on u8d_pkg and the channel interfaces in u8d_if.sv; the decoder is modeled
// inside this file and every code item is checked field by field.
module utf8_stream_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 10;
    localparam int QUIET_LIMIT    = 1000;
    localparam int RANDOM_ITEMS   = 1625;
    localparam int DRAIN_INTERVAL = 400;
    localparam int TAIL_CYCLES    = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_byte_if byte_ch ();
    u8d_code_if code_ch ();

    utf8_stream_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_code  (code_ch)
    );

    always #1 i_clk = ~i_clk;

    // Decoder model state
    logic [2:0]  open_left;
    logic [15:0] code_acc;
    logic [3:0]  open_len;
    logic        lead_unsup;

    u8d_pkg::t_result pending_codes[$];
    int      error_count = 0;
    int      bytes_sent  = 0;
    int      burst_left  = 0;
    int      quiet_cycles = 0;

    function automatic void clear_decoder();
        open_left  = '0;
        code_acc   = '0;
        open_len   = '0;
        lead_unsup = 1'b0;
    endfunction

    // Advance the model by one byte; returns 1 when the byte yields a code item
    function automatic bit decode_byte(input logic [7:0] b, input logic eob,
                                       output u8d_pkg::t_result res);
        int n;
        res = '0;
        if (open_left == 3'd0) begin
            n = 0;
            while (n < 8 && b[7 - n] == 1'b1)
                n++;
            if (n == 0) begin
                clear_decoder();
                res.code_point = {8'h00, b};
                res.seq_length = 4'd1;
                res.status     = u8d_pkg::ST_OK;
                return 1'b1;
            end
            if (n == 1) begin
                clear_decoder();
                res.seq_length = 4'd1;
                res.status     = u8d_pkg::ST_STRAY;
                return 1'b1;
            end
            open_len  = 4'(n);
            open_left = 3'(n - 1);
            if (n == 2) begin
                code_acc   = {8'h00, b & u8d_pkg::MASK_LEAD2};
                lead_unsup = 1'b0;
            end else if (n == 3) begin
                code_acc   = {8'h00, b & u8d_pkg::MASK_LEAD3};
                lead_unsup = 1'b0;
            end else begin
                code_acc   = '0;
                lead_unsup = 1'b1;
            end
        end else begin
            if (!lead_unsup)
                code_acc = {code_acc[9:0], 6'(b & u8d_pkg::MASK_CONT)};
            open_left = open_left - 3'd1;
            if (open_left == 3'd0) begin
                res.code_point = lead_unsup ? 16'h0000 : code_acc;
                res.seq_length = open_len;
                res.status     = lead_unsup ? u8d_pkg::ST_UNSUPPORTED : u8d_pkg::ST_OK;
                clear_decoder();
                return 1'b1;
            end
        end
        // end of buffer cuts the open sequence short
        if (eob) begin
            res.seq_length = open_len - 4'(open_left);
            res.status     = u8d_pkg::ST_TRUNCATED;
            clear_decoder();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Track accepted bytes, check code items, watch for a stuck handshake
    always @(posedge i_clk) begin : monitor
        u8d_pkg::t_result want;
        u8d_pkg::t_result got_expected;
        bit      has_code;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            has_code = decode_byte(byte_ch.data_byte, byte_ch.end_of_buffer, got_expected);
            if (has_code)
                pending_codes.push_back(got_expected);
        end
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected code item: code_point %0h seq_length %0d status %0d",
                       code_ch.code_point, code_ch.seq_length, code_ch.status);
                error_count++;
            end else begin
                want = pending_codes.pop_front();
                if (code_ch.code_point !== want.code_point) begin
                    $error("code_point: expected %0h, got %0h",
                           want.code_point, code_ch.code_point);
                    error_count++;
                end
                if (code_ch.seq_length !== want.seq_length) begin
                    $error("seq_length: expected %0d, got %0d",
                           want.seq_length, code_ch.seq_length);
                    error_count++;
                end
                if (code_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, code_ch.status);
                    error_count++;
                end
            end
        end
        if ((byte_ch.valid && byte_ch.ready) || (code_ch.valid && code_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: ready follows a randomly chosen stall mode
    initial begin : receiver
        int rx_cycle;
        int mode;
        rx_cycle = 0;
        mode = 0;
        code_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_cycle % 128 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: begin
                    code_ch.ready <= 1'b1;
                end
                1: begin
                    code_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    code_ch.ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    code_ch.ready <= ((rx_cycle % 11) < 4);
                end
            endcase
            rx_cycle++;
        end
    end

    // Send one byte; bursts of random length with random gaps between them
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                byte_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_buffer <= eob;
        do
            @(posedge i_clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Hold the sender off until every outstanding code item has been taken
    task automatic pause_until_drained();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] cont_byte();
        // mostly well-formed, sometimes any byte since the pattern is not checked
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic test_plain_and_stray();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_multibyte();
        send_byte(8'hc2, 1'b0);
        send_byte(8'ha9, 1'b0);
        // continuation bits not checked: 0xff contributes 0x3f
        send_byte(8'hdf, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
    endtask

    task automatic test_unsupported_lead();
        send_byte(8'hff, 1'b0);
        for (int i = 0; i < 7; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_truncation();
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b1);
        // lead byte carries the mark itself
        send_byte(8'hc3, 1'b1);
        send_byte(8'hf8, 1'b0);
        send_byte(8'h01, 1'b1);
        // sequence completing on the marked byte is a normal result
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b1);
    endtask

    task automatic test_random_stream();
        int          target;
        int          last_drain;
        int          kind;
        int          n;
        logic [7:0]  ones_mask;
        logic [7:0]  low_mask;
        target = bytes_sent + RANDOM_ITEMS;
        last_drain = bytes_sent;
        while (bytes_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_byte({1'b0, 7'($urandom)}, $urandom_range(0, 24) == 0);
            end else if (kind < 60) begin
                send_byte({3'b110, 5'($urandom)}, $urandom_range(0, 24) == 0);
                send_byte(cont_byte(), $urandom_range(0, 24) == 0);
            end else if (kind < 78) begin
                send_byte({4'b1110, 4'($urandom)}, $urandom_range(0, 24) == 0);
                send_byte(cont_byte(), $urandom_range(0, 24) == 0);
                send_byte(cont_byte(), $urandom_range(0, 24) == 0);
            end else if (kind < 86) begin
                // lead with four to eight leading ones, then its tail
                n = $urandom_range(4, 8);
                ones_mask = 8'hff << (8 - n);
                low_mask  = 8'hff >> (n + 1);
                send_byte(ones_mask | (8'($urandom) & low_mask),
                          $urandom_range(0, 24) == 0);
                for (int i = 1; i < n; i++)
                    send_byte(8'($urandom), $urandom_range(0, 24) == 0);
            end else if (kind < 93) begin
                send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 24) == 0);
            end else begin
                send_byte(8'($urandom), $urandom_range(0, 1) == 0);
            end
            if (bytes_sent - last_drain >= DRAIN_INTERVAL) begin
                pause_until_drained();
                last_drain = bytes_sent;
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = 8'h00;
        byte_ch.end_of_buffer = 1'b0;
        clear_decoder();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_and_stray();
        test_multibyte();
        test_unsupported_lead();
        test_truncation();
        pause_until_drained();
        test_random_stream();

        // let the last code items out
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
